/* design/sync_word_frame_extractor_assert.svh */
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef SYNC_WORD_FRAME_EXTRACTOR_ASSERT_SVH
`define SYNC_WORD_FRAME_EXTRACTOR_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define SWFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SWFE_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* design/swfe_pkg.sv */
// Types, constants and helper functions for the sync-word frame extractor.
// No dependencies; the front, queue, back and top-level files import this package.
package swfe_pkg;

    // Default length of the start-of-frame word in bytes (1 to 4).
    localparam int SYNC_LEN_DEF = 4;

    // Number of commands held between the classifier and the emitter.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic CFG_SYNC_WORD = 1'b0;
    localparam logic CFG_FRAME_ID  = 1'b1;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_MARKER  = 1'b1;

    // Receive phases; the unused code behaves as hunting.
    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_ID    = 2'd1,
        PH_COUNT = 2'd2
    } swfe_phase_t;

    // One unit of work for the emitter: a frame marker, or up to three
    // replayed sync bytes optionally followed by the received byte.
    typedef struct packed {
        logic        is_marker;
        logic [1:0]  rep_cnt;
        logic        emit_byte;
        logic [7:0]  data_byte;
        logic [31:0] counter;
        logic [31:0] offset;
    } swfe_cmd_t;

    // Byte k of the sync word, first expected byte in bits 7 to 0.
    function automatic logic [7:0] sync_byte(input logic [31:0] word, input logic [1:0] k);
        return word[{k, 3'b000} +: 8];
    endfunction

endpackage

/* design/swfe_if.sv */
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on nothing; used by the top level and the front and back parts.
interface swfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface swfe_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] frame_counter;
    logic [31:0] frame_offset;
    logic        last;

    modport source (output valid, output kind, output payload_byte, output frame_counter,
                    output frame_offset, output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input frame_counter,
                    input frame_offset, input last, output ready);
endinterface

/* design/swfe_front.sv */
// Classifier: takes one byte per request, tracks sync, identifier and counter
// phases and pushes one command per result-producing byte. Uses swfe_pkg.
module swfe_front
    import swfe_pkg::*;
#(
    parameter int SYNC_LEN = SYNC_LEN_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    swfe_in_if.sink       din,
    input  logic [31:0]   sync_word,
    input  logic [7:0]    frame_id,
    input  logic          q_full,
    output logic          push,
    output swfe_cmd_t     push_cmd
);

    localparam logic [2:0] LEN = 3'(SYNC_LEN);

    swfe_phase_t phase_reg, phase_next;
    logic        collecting_reg, collecting_next;
    logic [1:0]  matched_reg, matched_next;
    logic [1:0]  cidx_reg, cidx_next;
    logic [31:0] counter_reg, counter_next;
    logic [31:0] pcount_reg, pcount_next;

    logic        accept;
    logic [7:0]  sb0;
    logic [2:0]  m;
    logic [1:0]  rep;
    logic        emit;

    // A byte is taken whenever the command queue has room.
    assign din.ready = !q_full;
    assign accept    = din.valid && !q_full;
    assign sb0       = sync_byte(sync_word, 2'd0);

    // Phase handling and command construction.
    always_comb
    begin
        phase_next      = phase_reg;
        collecting_next = collecting_reg;
        matched_next    = matched_reg;
        cidx_next       = cidx_reg;
        counter_next    = counter_reg;
        pcount_next     = pcount_reg;
        push            = 1'b0;
        push_cmd        = '0;
        rep             = 2'd0;
        emit            = 1'b0;
        m               = {1'b0, matched_reg};
        if (m >= LEN)
        begin
            m = 3'd0;
        end
        if (accept)
        begin
            case (phase_reg)
                PH_ID:
                begin
                    phase_next = (din.data_byte == frame_id) ? PH_COUNT : PH_HUNT;
                end
                PH_COUNT:
                begin
                    counter_next[{cidx_reg, 3'b000} +: 8] = din.data_byte;
                    if (cidx_reg == 2'd3)
                    begin
                        push               = 1'b1;
                        push_cmd.is_marker = 1'b1;
                        push_cmd.counter   = counter_next;
                        push_cmd.offset    = pcount_reg;
                        cidx_next          = 2'd0;
                        phase_next         = PH_HUNT;
                        collecting_next    = 1'b1;
                    end
                    else
                    begin
                        cidx_next = cidx_reg + 2'd1;
                    end
                end
                default:
                begin
                    // Hunting: extend, restart or drop the partial match.
                    if (din.data_byte == sync_byte(sync_word, m[1:0]))
                    begin
                        m = m + 3'd1;
                    end
                    else
                    begin
                        if (collecting_reg)
                        begin
                            rep  = m[1:0];
                            emit = (din.data_byte != sb0);
                        end
                        m = (din.data_byte == sb0) ? 3'd1 : 3'd0;
                    end
                    if (m >= LEN)
                    begin
                        matched_next    = 2'd0;
                        phase_next      = PH_ID;
                        collecting_next = 1'b0;
                    end
                    else
                    begin
                        matched_next = m[1:0];
                        phase_next   = PH_HUNT;
                    end
                    push               = (rep != 2'd0) || emit;
                    push_cmd.rep_cnt   = rep;
                    push_cmd.emit_byte = emit;
                    push_cmd.data_byte = din.data_byte;
                    pcount_next        = pcount_reg + 32'(rep) + 32'(emit);
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            collecting_reg <= 1'b0;
            matched_reg    <= 2'd0;
            cidx_reg       <= 2'd0;
            counter_reg    <= '0;
            pcount_reg     <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            collecting_reg <= collecting_next;
            matched_reg    <= matched_next;
            cidx_reg       <= cidx_next;
            counter_reg    <= counter_next;
            pcount_reg     <= pcount_next;
        end
    end

endmodule

/* design/swfe_queue.sv */
// Short command queue between the classifier and the emitter.
// Uses swfe_pkg and the assertion macros.
`include "sync_word_frame_extractor_assert.svh"
module swfe_queue
    import swfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  swfe_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output swfe_cmd_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    swfe_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `SWFE_NEVER(a_no_push_full, push && full, "command pushed into a full queue")
    `SWFE_NEVER(a_no_pop_empty, pop && !q_valid, "command popped from an empty queue")
    `SWFE_NEVER(a_count_range, count_reg > CNT_FULL, "queue fill count out of range")

endmodule

/* design/swfe_back.sv */
// Emitter: expands each queued command into one result per cycle and holds
// it in an output register until taken. Uses swfe_pkg and assertion macros.
`include "sync_word_frame_extractor_assert.svh"
module swfe_back
    import swfe_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   sync_word,
    input  logic          q_valid,
    input  swfe_cmd_t     head,
    output logic          pop,
    swfe_out_if.source    dout
);

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  pos_reg, pos_next;
    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic [31:0] counter_reg;
    logic [31:0] offset_reg;
    logic        last_reg;

    logic [2:0]  total;
    logic        is_last;
    logic        load;
    logic [7:0]  res_byte;

    // Results in this command, and whether the current one ends it.
    assign total   = head.is_marker ? 3'd1 : ({1'b0, head.rep_cnt} + 3'(head.emit_byte));
    assign is_last = (({1'b0, pos_reg} + 3'd1) == total);
    assign load    = q_valid && (!out_valid_reg || dout.ready);
    assign pop     = load && is_last;

    // Replayed sync bytes come first, then the received byte.
    assign res_byte = (pos_reg < head.rep_cnt) ? sync_byte(sync_word, pos_reg)
                                               : head.data_byte;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            pos_next       = is_last ? 2'd0 : pos_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= is_last;
            if (head.is_marker)
            begin
                kind_reg    <= KIND_MARKER;
                byte_reg    <= 8'd0;
                counter_reg <= head.counter;
                offset_reg  <= head.offset;
            end
            else
            begin
                kind_reg    <= KIND_PAYLOAD;
                byte_reg    <= res_byte;
                counter_reg <= 32'd0;
                offset_reg  <= 32'd0;
            end
        end
    end

    assign dout.valid         = out_valid_reg;
    assign dout.kind          = kind_reg;
    assign dout.payload_byte  = byte_reg;
    assign dout.frame_counter = counter_reg;
    assign dout.frame_offset  = offset_reg;
    assign dout.last          = last_reg;

    `SWFE_ASSERT(a_pos_in_cmd, q_valid |-> ({1'b0, pos_reg} < total), "position beyond command")
    `SWFE_ASSERT(a_mid_cmd_held, (pos_reg != 2'd0) |-> q_valid, "command left mid-expansion")
    `SWFE_ASSERT(a_marker_last, (dout.valid && dout.kind) |-> dout.last, "marker not last")

endmodule

/* design/sync_word_frame_extractor.sv */
// Sync-word frame extractor: one received byte is accepted per cycle while the
// two-entry command queue has room. A classifier handles each byte as it is
// accepted; an emitter then delivers one result per cycle from a registered output
// while the receiver takes them. A byte may yield a marker, a payload byte, or a
// replayed sync prefix of up to three bytes plus the byte.
// Input requests stall only while the queue is full, which happens when such
// replays or a stalled receiver back it up. The first result of a byte passes
// through the command queue and the output register before it is offered. The
// user must write the registers through cfg_we, cfg_index and cfg_data only while
// the block is idle; the block itself does not enforce this.
module sync_word_frame_extractor
    import swfe_pkg::*;
#(
    parameter int SYNC_LEN = SYNC_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    swfe_in_if.sink     din,
    swfe_out_if.source  dout
);

    logic [31:0] sync_word_reg;
    logic [7:0]  frame_id_reg;

    logic        q_full;
    logic        q_valid;
    logic        push;
    logic        pop;
    swfe_cmd_t   push_cmd;
    swfe_cmd_t   head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= '0;
            frame_id_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_WORD: sync_word_reg <= cfg_data;
                CFG_FRAME_ID:  frame_id_reg  <= cfg_data[7:0];
                default:       sync_word_reg <= sync_word_reg;
            endcase
        end
    end

    swfe_front #(
        .SYNC_LEN (SYNC_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .sync_word (sync_word_reg),
        .frame_id  (frame_id_reg),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    swfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    swfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sync_word (sync_word_reg),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .dout      (dout)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the sync-word frame extractor.
// Needs swfe_pkg, the swfe_in_if and swfe_out_if channels and the top level of the block.
// A deframer predictor runs beside the block; every result is checked against it in order.
module tb_top;
    import swfe_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PRINT_CAP    = 50;

    // One expected or observed result.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [31:0] frame_counter;
        logic [31:0] frame_offset;
        logic        last;
    } deframe_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    swfe_in_if  in_ch ();
    swfe_out_if out_ch ();

    sync_word_frame_extractor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (in_ch),
        .dout      (out_ch)
    );

    // Shadow copies of the registers and of the deframer state.
    logic [31:0]     sync_word_shadow;
    logic [7:0]      frame_id_shadow;
    swfe_phase_t     rx_phase;
    logic            collecting;
    int unsigned     sync_matched;
    int unsigned     counter_lane;
    logic [31:0]     counter_acc;
    logic [31:0]     payload_total;

    deframe_result_t pending_results[$];
    int unsigned     mismatch_count;
    int unsigned     bytes_sent;
    int unsigned     cycle_count;
    logic            steady;

    always #4 clk = ~clk;

    // Byte k of the start-of-frame word.
    function automatic logic [7:0] sync_lane(input int unsigned k);
        return sync_word_shadow[8 * (k % 4) +: 8];
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic push_payload(input logic [7:0] v);
        deframe_result_t r;
        r.kind          = KIND_PAYLOAD;
        r.payload_byte  = v;
        r.frame_counter = '0;
        r.frame_offset  = '0;
        r.last          = 1'b0;
        pending_results.push_back(r);
        payload_total++;
    endtask

    // Predict the results caused by one accepted byte.
    task automatic deframe_byte(input logic [7:0] b);
        deframe_result_t mark;
        int unsigned     produced;
        int unsigned     m;
        produced = 0;
        case (rx_phase)
            PH_ID:
                rx_phase = (b == frame_id_shadow) ? PH_COUNT : PH_HUNT;
            PH_COUNT:
            begin
                counter_acc[8 * counter_lane +: 8] = b;
                if (counter_lane == 3) begin
                    mark.kind          = KIND_MARKER;
                    mark.payload_byte  = '0;
                    mark.frame_counter = counter_acc;
                    mark.frame_offset  = payload_total;
                    mark.last          = 1'b0;
                    pending_results.push_back(mark);
                    produced++;
                    counter_lane = 0;
                    rx_phase     = PH_HUNT;
                    collecting   = 1'b1;
                end
                else begin
                    counter_lane++;
                end
            end
            default:
            begin
                // Hunting; a broken partial match replays its prefix once collecting.
                m = sync_matched;
                if (m >= SYNC_LEN_DEF)
                    m = 0;
                if (b == sync_lane(m)) begin
                    m++;
                end
                else begin
                    if (collecting) begin
                        for (int k = 0; k < m; k++) begin
                            push_payload(sync_lane(k));
                            produced++;
                        end
                        if (b != sync_lane(0)) begin
                            push_payload(b);
                            produced++;
                        end
                    end
                    m = (b == sync_lane(0)) ? 1 : 0;
                end
                if (m >= SYNC_LEN_DEF) begin
                    m          = 0;
                    rx_phase   = PH_ID;
                    collecting = 1'b0;
                end
                else begin
                    rx_phase = PH_HUNT;
                end
                sync_matched = m;
            end
        endcase
        if (produced > 0)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    // Offer one byte, with random idle cycles ahead of it outside the steady stretch, and wait for its request.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 32) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Stop offering bytes and let every outstanding result arrive.
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SYNC_WORD)
            sync_word_shadow = v;
        else
            frame_id_shadow = v[7:0];
    endtask

    // Payload with occasional broken sync prefixes, then a header that is usually good.
    task automatic send_frame();
        int unsigned n_payload;
        int unsigned plen;
        logic [7:0]  id;
        n_payload = $urandom_range(10);
        for (int i = 0; i < n_payload; i++) begin
            if ($urandom_range(99) < 20) begin
                plen = $urandom_range(SYNC_LEN_DEF - 1, 1);
                for (int k = 0; k < plen; k++)
                    send_byte(sync_lane(k));
            end
            send_byte(8'($urandom_range(255)));
        end
        plen = ($urandom_range(99) < 90) ? SYNC_LEN_DEF : $urandom_range(SYNC_LEN_DEF - 1, 1);
        for (int k = 0; k < plen; k++)
            send_byte(sync_lane(k));
        id = ($urandom_range(99) < 85) ? frame_id_shadow : 8'($urandom_range(255));
        send_byte(id);
        for (int k = 0; k < 4; k++)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic run_frames(input logic [31:0] sw, input logic [7:0] id, input int unsigned n);
        int unsigned stop_at;
        wait_idle();
        write_reg(CFG_SYNC_WORD, sw);
        write_reg(CFG_FRAME_ID, {24'd0, id});
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
            send_frame();
    endtask

    // Wrong identifier, a good header, payload extremes and prefix replays.
    task automatic test_directed();
        logic [7:0] seq[] = '{8'h11,
                              8'h7A, 8'h2E, 8'h91, 8'hD3, 8'h00,
                              8'h7A, 8'h2E, 8'h91, 8'hD3, 8'h5C, 8'hFF, 8'h00, 8'h80, 8'h01,
                              8'h00, 8'hFF,
                              8'h7A, 8'h2E, 8'h7A, 8'h2E, 8'h91, 8'h55};
        wait_idle();
        write_reg(CFG_SYNC_WORD, 32'hD391_2E7A);
        write_reg(CFG_FRAME_ID, 32'h0000_005C);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_zero_config();
        run_frames(32'h0000_0000, 8'h00, 80);
    endtask

    task automatic test_ones_config();
        run_frames(32'hFFFF_FFFF, 8'hFF, 80);
    endtask

    // A word of one repeated byte makes every broken match restart at zero.
    task automatic test_repeated_sync();
        run_frames(32'h3C3C_3C3C, 8'($urandom_range(255)), 80);
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        run_frames($urandom, 8'($urandom_range(255)), 100);
        steady = 1'b0;
    endtask

    task automatic test_random_configs();
        for (int i = 0; i < 3; i++)
            run_frames($urandom, 8'($urandom_range(255)), 40);
    endtask

    // Receiver stalls at random except during the steady stretch.
    always @(negedge clk)
        out_ch.ready <= steady || ($urandom_range(99) >= 32);

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk) begin
        deframe_result_t seen;
        deframe_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            seen.kind          = out_ch.kind;
            seen.payload_byte  = out_ch.payload_byte;
            seen.frame_counter = out_ch.frame_counter;
            seen.frame_offset  = out_ch.frame_offset;
            seen.last          = out_ch.last;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", seen));
            end
            else begin
                want = pending_results.pop_front();
                if (seen.kind !== want.kind)
                    report_mismatch($sformatf("kind %b, want %b", seen.kind, want.kind));
                if (seen.payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %h, want %h",
                                              seen.payload_byte, want.payload_byte));
                if (seen.frame_counter !== want.frame_counter)
                    report_mismatch($sformatf("frame_counter %h, want %h",
                                              seen.frame_counter, want.frame_counter));
                if (seen.frame_offset !== want.frame_offset)
                    report_mismatch($sformatf("frame_offset %0d, want %0d",
                                              seen.frame_offset, want.frame_offset));
                if (seen.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", seen.last, want.last));
            end
        end
    end

    // Guard against a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_SYNC_WORD;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        steady           = 1'b0;
        mismatch_count   = 0;
        bytes_sent       = 0;
        sync_word_shadow = '0;
        frame_id_shadow  = '0;
        rx_phase         = PH_HUNT;
        collecting       = 1'b0;
        sync_matched     = 0;
        counter_lane     = 0;
        counter_acc      = '0;
        payload_total    = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_zero_config();
        test_ones_config();
        test_repeated_sync();
        test_steady_stream();
        test_random_configs();
        wait_idle();

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
